// File: rtl/integer_to_ascii_formatter_core_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_macros
// Assertion macros shared by the formatter rtl.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define I2A_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2a assertion failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2a assertion failed");

`endif

// File: rtl/i2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers of the integer to ascii formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int MAX_DIGITS_DEF = 20;
  localparam int MAX_WIDTH_DEF  = 40;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 2;
  localparam int FW_W    = 6;
  localparam int ROOM_W  = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_DEC   = 2'd0;
  localparam logic [RADIX_W-1:0] RADIX_LOWER = 2'd1;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_STEP,
    OP_SHIFT
  } dab_op_t;

  typedef struct packed {
    dab_op_t              op;
    logic                 load_dec;
    logic [VALUE_W-1:0]   load_val;
  } dab_ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic [3:0]           top_digit;
  } dab_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    begin
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
        digit_char = CH_ZERO + {4'b0000, d};
      end else begin
        digit_char = base + {4'b0000, d} - 8'd10;
      end
    end
  endfunction

endpackage

// File: rtl/i2a_dabble.sv
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_core_macros.svh"
// ----------------------------------------------------------------------------
// i2a_dabble
// Digit register with a shared shift-add-3 step for binary to decimal
// conversion, a direct nibble load for hex and a one-digit left shift for
// reading the digits out most significant first.
// ----------------------------------------------------------------------------
module i2a_dabble
  import i2a_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dab_ctrl_t ctrl,
  output dab_stat_t stat
);

  localparam int DW    = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic [DW-1:0]      bcd_r, bcd_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]      adj;

  // add 3 to every digit of 5 or more
  always_comb begin
    logic [3:0] nib;
    nib = 4'd0;
    adj = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      nib = bcd_r[i*4 +: 4];
      adj[i*4 +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    cnt_nxt = cnt_r;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        if (ctrl.load_dec) begin
          bcd_nxt = '0;
          bin_nxt = ctrl.load_val;
          cnt_nxt = CNT_W'(VALUE_W);
        end else begin
          bcd_nxt = DW'(ctrl.load_val);
          cnt_nxt = '0;
        end
      end
      OP_STEP: begin
        bcd_nxt = {adj[DW-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_SHIFT: begin
        bcd_nxt = {bcd_r[DW-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  assign stat.busy      = (cnt_r != '0);
  assign stat.top_digit = bcd_r[DW-1 -: 4];

  `I2A_ASSERT_IMPL(a_step_only_busy, clk, rst_n, ctrl.op == OP_STEP, cnt_r != '0)
  `I2A_ASSERT_NEXT(a_dec_load_busy, clk, rst_n, ctrl.op == OP_LOAD && ctrl.load_dec, stat.busy)
  `I2A_ASSERT_NEXT(a_hex_load_idle, clk, rst_n, ctrl.op == OP_LOAD && !ctrl.load_dec, !stat.busy)

endmodule

// File: rtl/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_core_macros.svh"
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one 64-bit number per input item as ascii text, one character per
// output item: optional minus sign, pad characters, then the digits.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with the number, signedness, radix,
//   pad choice, field width and room. in_stall is high from acceptance
//   until the last character of that number has been loaded into the
//   output register, so one number is in flight at a time.
//   output channel: out_valid / out_stall, one character per item, with
//   out_is_last on the final one. if room is zero a single item with
//   out_is_empty and out_is_last set and out_char_out zero is sent.
//   operation: decimal conversion steps the shared shift-add-3 unit through
//   all the input bits, hex loads directly. then the sign is emitted if the
//   number is negative, each unused leading digit position above the field
//   width (at most MAX_DIGITS-1) is skipped, and the characters are emitted.
//   the digit register and its shift-add unit set the conversion time, the
//   single output register sets one character per cycle while out_stall is low.
//   when out_stall is high the output register holds its character and
//   the sequencer waits. reset is synchronous, active low, empties the
//   output register and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
  import i2a_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_is_signed,
  input  logic [RADIX_W-1:0] in_radix_mode,
  input  logic               in_zero_pad,
  input  logic [FW_W-1:0]    in_field_width,
  input  logic [ROOM_W-1:0]  in_room,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_char_out,
  output logic               out_is_last,
  output logic               out_is_empty
);

  localparam int SPAN  = (MAX_WIDTH > MAX_DIGITS) ? MAX_WIDTH : MAX_DIGITS;
  localparam int J_W   = $clog2(SPAN);
  localparam int CMP_W = ((J_W > FW_W) ? J_W : FW_W) + 1;

  state_t              state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic                upper_r, upper_nxt;
  logic [CHAR_W-1:0]   pad_r, pad_nxt;
  logic [FW_W-1:0]     width_r, width_nxt;
  logic [ROOM_W-1:0]   room_r, room_nxt;
  logic [J_W-1:0]      j_r, j_nxt;
  logic                seen_r, seen_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_empty_r, out_empty_nxt;

  dab_ctrl_t           dab_ctrl;
  dab_stat_t           dab_stat;

  logic                accept;
  logic                out_free;
  logic                load_out;
  logic                load_last;
  logic                neg_in;
  logic [VALUE_W-1:0]  mag_in;
  logic [FW_W-1:0]     width_sat;
  logic [CMP_W-1:0]    span_in;
  logic                in_range;
  logic [3:0]          dig;
  logic                sig;
  logic                skip;

  i2a_dabble #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dab_ctrl),
    .stat  (dab_stat)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign neg_in    = in_is_signed && in_value[VALUE_W-1];
  assign mag_in    = neg_in ? (VALUE_W'(0) - in_value) : in_value;
  assign width_sat = (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_field_width;
  assign span_in   = ((CMP_W'(width_sat) > CMP_W'(MAX_DIGITS)) ? CMP_W'(width_sat)
                                                               : CMP_W'(MAX_DIGITS))
                     - CMP_W'(1);

  // digit at position j, zero above the digit register
  assign in_range = (CMP_W'(j_r) < CMP_W'(MAX_DIGITS));
  assign dig      = in_range ? dab_stat.top_digit : 4'd0;
  assign sig      = seen_r || (dig != 4'd0) || (j_r == '0);
  assign skip     = (CMP_W'(j_r) >= CMP_W'(width_r)) && !sig;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    pad_nxt       = pad_r;
    width_nxt     = width_r;
    room_nxt      = room_r;
    j_nxt         = j_r;
    seen_nxt      = seen_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    load_out      = 1'b0;
    load_last     = 1'b0;
    dab_ctrl.op       = OP_HOLD;
    dab_ctrl.load_dec = (in_radix_mode == RADIX_DEC);
    dab_ctrl.load_val = mag_in;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dab_ctrl.op = OP_LOAD;
          neg_nxt     = neg_in;
          upper_nxt   = (in_radix_mode != RADIX_LOWER);
          pad_nxt     = in_zero_pad ? CH_ZERO : CH_SPACE;
          width_nxt   = width_sat;
          room_nxt    = in_room;
          j_nxt       = J_W'(span_in);
          seen_nxt    = 1'b0;
          state_nxt   = (in_radix_mode == RADIX_DEC) ? ST_CONV : ST_SIGN;
        end
      end
      ST_CONV: begin
        if (dab_stat.busy) begin
          dab_ctrl.op = OP_STEP;
        end else begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (room_r == '0) begin
          if (out_free) begin
            load_out      = 1'b1;
            load_last     = 1'b1;
            out_char_nxt  = CH_NONE;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (neg_r) begin
          if (out_free) begin
            load_out      = 1'b1;
            load_last     = (room_r == ROOM_W'(1));
            out_char_nxt  = CH_MINUS;
            out_last_nxt  = load_last;
            out_empty_nxt = 1'b0;
            room_nxt      = room_r - ROOM_W'(1);
            state_nxt     = load_last ? ST_IDLE : ST_EMIT;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          j_nxt = j_r - J_W'(1);
          if (in_range) begin
            dab_ctrl.op = OP_SHIFT;
          end
        end else if (out_free) begin
          load_out      = 1'b1;
          load_last     = (room_r == ROOM_W'(1)) || (j_r == '0);
          out_char_nxt  = sig ? digit_char(dig, upper_r) : pad_r;
          out_last_nxt  = load_last;
          out_empty_nxt = 1'b0;
          room_nxt      = room_r - ROOM_W'(1);
          j_nxt         = j_r - J_W'(1);
          seen_nxt      = sig;
          if (in_range) begin
            dab_ctrl.op = OP_SHIFT;
          end
          if (load_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    upper_r     <= upper_nxt;
    pad_r       <= pad_nxt;
    width_r     <= width_nxt;
    room_r      <= room_nxt;
    j_r         <= j_nxt;
    seen_r      <= seen_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_is_last  = out_last_r;
  assign out_is_empty = out_empty_r;

  `I2A_ASSERT_IMPL(a_empty_is_last, clk, rst_n, out_valid && out_is_empty,
                   out_is_last && (out_char_out == CH_NONE))
  `I2A_ASSERT_IMPL(a_emit_has_room, clk, rst_n, state_r == ST_EMIT, room_r != '0)
  `I2A_ASSERT_NEXT(a_last_to_idle, clk, rst_n, load_out && load_last, state_r == ST_IDLE)
  `I2A_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != ST_IDLE)

endmodule

// File: test/integer_to_ascii_formatter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_tb
// Drives numbers into the formatter with random gaps and output back-pressure
// and checks every emitted character against a local model of the sign, pad
// and digit text, truncated to the room given with each number.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_tb;
  import i2a_pkg::*;

  localparam logic [RADIX_W-1:0] RADIX_UPPER     = 2'd2;
  localparam logic [RADIX_W-1:0] RADIX_UPPER_ALT = 2'd3;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
    logic [RADIX_W-1:0] radix;
    logic               zero_pad;
    logic [FW_W-1:0]    width;
    logic [ROOM_W-1:0]  room;
    bit                 drain;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic               in_is_signed = 1'b0;
  logic [RADIX_W-1:0] in_radix_mode = RADIX_DEC;
  logic               in_zero_pad = 1'b0;
  logic [FW_W-1:0]    in_field_width = '0;
  logic [ROOM_W-1:0]  in_room = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_char_out;
  logic               out_is_last;
  logic               out_is_empty;

  number_t    number_q[$];
  text_char_t char_q[$];
  int         errors = 0;
  int         send_gap = 0;
  int         recv_hold = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;
  bit         drained = 1'b1;

  integer_to_ascii_formatter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_is_signed   (in_is_signed),
    .in_radix_mode  (in_radix_mode),
    .in_zero_pad    (in_zero_pad),
    .in_field_width (in_field_width),
    .in_room        (in_room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_is_last    (out_is_last),
    .out_is_empty   (out_is_empty)
  );

  always #1 clk = ~clk;

  // sign, pad and digits of one number, cut to room
  function automatic void format_number(input logic [VALUE_W-1:0] value, input logic sgn,
                                        input logic [RADIX_W-1:0] radix, input logic zpad,
                                        input logic [FW_W-1:0] fw, input logic [ROOM_W-1:0] room);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digs[$];
    logic [CHAR_W-1:0]  line[$];
    logic [CHAR_W-1:0]  ch;
    logic [3:0]         d;
    int                 width;
    int                 n;
    text_char_t         tc;
    mag = value;
    width = (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(fw);
    if (sgn && value[VALUE_W-1]) begin
      mag = 64'd0 - value;
      line.push_back(CH_MINUS);
    end
    do begin
      if (radix == RADIX_DEC) begin
        d = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end else begin
        d = mag[3:0];
        mag = mag >> 4;
      end
      if (d < 4'd10) begin
        ch = CH_ZERO + {4'b0000, d};
      end else begin
        ch = ((radix == RADIX_LOWER) ? CH_LOWER_A : CH_UPPER_A) + {4'b0000, d} - 8'd10;
      end
      digs.push_front(ch);
    end while (mag != 0 && digs.size() < MAX_DIGITS_DEF);
    for (int i = digs.size(); i < width; i++) line.push_back(zpad ? CH_ZERO : CH_SPACE);
    foreach (digs[i]) line.push_back(digs[i]);
    n = (line.size() > room) ? int'(room) : line.size();
    if (n == 0) begin
      tc.ch = CH_NONE;
      tc.last = 1'b1;
      tc.empty = 1'b1;
      char_q.push_back(tc);
    end
    for (int i = 0; i < n; i++) begin
      tc.ch = line[i];
      tc.last = (i == n - 1);
      tc.empty = 1'b0;
      char_q.push_back(tc);
    end
  endfunction

  function automatic int pick_wait(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void add_number(input logic [VALUE_W-1:0] value, input logic sgn,
                                     input logic [RADIX_W-1:0] radix, input logic zpad,
                                     input logic [FW_W-1:0] fw, input logic [ROOM_W-1:0] room,
                                     input bit drain);
    number_t it;
    it.value = value;
    it.is_signed = sgn;
    it.radix = radix;
    it.zero_pad = zpad;
    it.width = fw;
    it.room = room;
    it.drain = drain;
    number_q.push_back(it);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 999));
      2: v = 64'd0 - 64'($urandom_range(1, 1000));
      3: v = 64'd1 << $urandom_range(0, 63);
      4: v = (64'd1 << $urandom_range(0, 63)) - 64'd1;
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic present(input number_t it);
    in_valid <= 1'b1;
    in_value <= it.value;
    in_is_signed <= it.is_signed;
    in_radix_mode <= it.radix;
    in_zero_pad <= it.zero_pad;
    in_field_width <= it.width;
    in_room <= it.room;
  endtask

  // driver
  always @(posedge clk) begin : drv
    bit ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      ready = number_q.size() > 0 && (!number_q[0].drain || drained);
      if (in_valid && !in_stall) begin
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        send_gap <= pick_wait(send_calm);
        if (pick_wait(send_calm) == 0 && number_q.size() > 0 && !number_q[0].drain) begin
          present(number_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (ready) begin
          present(number_q.pop_front());
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin : mon
    text_char_t want;
    int h;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold <= 0;
      drained <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected item char %h last %b empty %b", $time,
                   out_char_out, out_is_last, out_is_empty);
          errors++;
        end else begin
          want = char_q.pop_front();
          if (out_char_out !== want.ch) begin
            $display("%0t: char expected %h actual %h", $time, want.ch, out_char_out);
            errors++;
          end
          if (out_is_last !== want.last) begin
            $display("%0t: is_last expected %b actual %b", $time, want.last, out_is_last);
            errors++;
          end
          if (out_is_empty !== want.empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, want.empty, out_is_empty);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        h = pick_wait(recv_calm);
        recv_hold <= h;
        out_stall <= (h != 0);
      end else if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_stall <= (recv_hold > 1);
      end
      if (in_valid && !in_stall) begin
        format_number(in_value, in_is_signed, in_radix_mode, in_zero_pad, in_field_width,
                      in_room);
      end
      drained <= (char_q.size() == 0);
    end
  end

  initial begin
    logic [FW_W-1:0]   fw;
    logic [ROOM_W-1:0] rm;
    // directed numbers
    add_number(64'd0, 1'b0, RADIX_DEC, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number('1, 1'b0, RADIX_DEC, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number('1, 1'b1, RADIX_DEC, 1'b1, 6'd3, 6'd63, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b1, RADIX_DEC, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b1, RADIX_LOWER, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b0, RADIX_UPPER, 1'b1, 6'd18, 6'd63, 1'b0);
    add_number(64'hdead_beef_cafe_f00d, 1'b0, RADIX_LOWER, 1'b1, 6'd20, 6'd63, 1'b1);
    add_number(64'hdead_beef_cafe_f00d, 1'b0, RADIX_UPPER, 1'b0, 6'd20, 6'd63, 1'b0);
    add_number(64'hdead_beef_cafe_f00d, 1'b0, RADIX_UPPER_ALT, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number(64'd12345, 1'b0, RADIX_DEC, 1'b0, 6'd40, 6'd63, 1'b0);
    add_number(64'd0 - 64'd5, 1'b1, RADIX_DEC, 1'b1, 6'd40, 6'd63, 1'b0);
    add_number(64'd0 - 64'd7, 1'b1, RADIX_UPPER, 1'b0, 6'd63, 6'd63, 1'b0);
    add_number(64'd99, 1'b0, RADIX_DEC, 1'b1, 6'd41, 6'd63, 1'b0);
    add_number(64'd77, 1'b0, RADIX_LOWER, 1'b0, 6'd50, 6'd45, 1'b0);
    add_number(64'd123, 1'b0, RADIX_DEC, 1'b0, 6'd0, 6'd0, 1'b1);
    add_number(64'd0 - 64'd42, 1'b1, RADIX_DEC, 1'b0, 6'd0, 6'd1, 1'b0);
    add_number(64'd8, 1'b0, RADIX_DEC, 1'b1, 6'd10, 6'd3, 1'b0);
    add_number(64'h7fff_ffff_ffff_ffff, 1'b1, RADIX_DEC, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number(64'd0, 1'b0, RADIX_LOWER, 1'b0, 6'd0, 6'd0, 1'b0);
    add_number(64'd0, 1'b0, RADIX_UPPER, 1'b0, 6'd0, 6'd1, 1'b0);
    add_number('1, 1'b1, RADIX_UPPER, 1'b0, 6'd0, 6'd63, 1'b0);
    add_number(64'd42, 1'b1, RADIX_DEC, 1'b1, 6'd5, 6'd63, 1'b0);
    add_number(64'hfedc_ba98_7654_3210, 1'b0, RADIX_LOWER, 1'b0, 6'd0, 6'd10, 1'b0);
    add_number('1, 1'b0, RADIX_DEC, 1'b1, 6'd40, 6'd63, 1'b1);
    // random numbers
    for (int i = 0; i < 440; i++) begin
      fw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
      case ($urandom_range(0, 3))
        0: rm = 6'($urandom_range(0, 63));
        1: rm = 6'($urandom_range(0, 5));
        default: rm = 6'd63;
      endcase
      add_number(rand_value(), 1'($urandom), 2'($urandom_range(0, 3)), 1'($urandom), fw, rm,
                 i == 0 || $urandom_range(0, 59) == 0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (number_q.size() != 0 || in_valid);
    do @(negedge clk); while (char_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && char_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
